[sv/angle_tracking_pll_defines.svh]
// assertion macros for the angle tracking pll
`ifndef ANGLE_TRACKING_PLL_DEFINES_SVH
`define ANGLE_TRACKING_PLL_DEFINES_SVH
`define ATP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ATP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[sv/atp_pkg.sv]
// package with payload types and codes of the angle tracking pll
package atp_pkg;
    localparam logic [1:0] CMD_VECTOR = 2'd0;
    localparam logic [1:0] CMD_ERROR  = 2'd1;
    localparam logic [1:0] CMD_ANGLE  = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [2:0] REG_SPEED_ALPHA = 3'd2;
    localparam logic [2:0] REG_PERIOD      = 3'd3;
    localparam logic [2:0] REG_RATE        = 3'd4;
    localparam logic [2:0] REG_FFD_ALPHA   = 3'd5;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] alpha_in;
        logic signed [15:0] beta_in;
        logic signed [31:0] error_in;
        logic [15:0]        angle_in;
    } t_in;

    typedef struct packed {
        logic [15:0]        angle_out;
        logic signed [31:0] speed_out;
        logic signed [31:0] filtered_speed_out;
        logic signed [15:0] phase_error_out;
        logic signed [31:0] ffd_speed_out;
    } t_out;

    typedef struct packed {
        logic               start;
        logic signed [33:0] a;
        logic signed [33:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic signed [67:0] p;
    } t_mul_rsp;
endpackage

[sv/atp_serial_mul.sv]
// shift-add signed multiplier, two bits of the multiplier per cycle
module atp_serial_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  atp_pkg::t_mul_req i_req,
    output atp_pkg::t_mul_rsp o_rsp
);
    logic               r_busy, n_busy;
    logic [4:0]         r_cnt, n_cnt;
    logic signed [67:0] r_acc, n_acc;
    logic signed [67:0] r_mcand, n_mcand;
    logic [33:0]        r_mplier, n_mplier;
    logic               r_done, n_done;
    logic signed [67:0] w_p0, w_p1;

    always_comb begin
        w_p0 = r_mplier[0] ? r_mcand : '0;
        w_p1 = r_mplier[1] ? (r_mcand <<< 1) : '0;
        if (r_cnt == 5'd16) begin
            w_p1 = r_mplier[1] ? -(r_mcand <<< 1) : '0;
        end
    end

    always_comb begin
        n_busy = r_busy; n_cnt = r_cnt; n_acc = r_acc;
        n_mcand = r_mcand; n_mplier = r_mplier; n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1; n_cnt = '0; n_acc = '0;
            n_mcand = 68'(i_req.a); n_mplier = i_req.b;
        end else if (r_busy) begin
            n_acc = r_acc + w_p0 + w_p1;
            n_mcand = r_mcand <<< 2;
            n_mplier = r_mplier >> 2;
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd16) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_acc <= n_acc; r_mcand <= n_mcand; r_mplier <= n_mplier;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;
endmodule

[sv/angle_tracking_pll.sv]
// angle tracking pll top level: sequencer, state and channels
// usage: each accepted input transaction is one sample; cmd picks vector,
// direct error, absolute angle or tick. one result transaction follows per
// sample. configuration is written on the cfg channel (index, data) while
// idle. the sequencer runs every product through one serial multiplier:
// every sample needs 5 (integrator, speed, two filter products, angle
// step), angle 3 more, vector 10 more (sine and cosine polynomials, four
// each, and the two error products) plus the VERR and WAIT states. o_valid
// is registered from the S_OUT state; samples are accepted one at a time.
// after synchronous reset the integrator, filter, angle and error state is
// zero, filter weights one, sample rate 10000. a stalled result holds in
// the output register and the next sample waits until the result is taken.
`include "angle_tracking_pll_defines.svh"
module angle_tracking_pll #(
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  atp_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output atp_pkg::t_out o_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    typedef enum logic [17:0] {
        S_IDLE = 18'b000000000000000001,
        S_SZ2  = 18'b000000000000000010,
        S_ST1  = 18'b000000000000000100,
        S_ST2  = 18'b000000000000001000,
        S_ST3  = 18'b000000000000010000,
        S_SIN  = 18'b000000000000100000,
        S_COS  = 18'b000000000001000000,
        S_VERR = 18'b000000000010000000,
        S_FFD  = 18'b000000000100000000,
        S_FFA  = 18'b000000001000000000,
        S_FFB  = 18'b000000010000000000,
        S_INT  = 18'b000000100000000000,
        S_PRP  = 18'b000001000000000000,
        S_LPA  = 18'b000010000000000000,
        S_LPB  = 18'b000100000000000000,
        S_ANG  = 18'b001000000000000000,
        S_OUT  = 18'b010000000000000000,
        S_WAIT = 18'b100000000000000000
    } t_state;

    localparam int Shift = 16 - TRIG_TABLE_BITS;

    t_state r_state, n_state;
    logic   r_issued, n_issued;

    logic signed [31:0] r_kp, r_ki;
    logic [15:0]        r_sa, r_fa;
    logic [31:0]        r_per;
    logic [17:0]        r_rate;

    logic signed [31:0] r_integ, r_fspd, r_ffd, r_omega, r_tmp;
    logic [15:0]        r_ang, r_frac, r_prev;
    logic signed [15:0] r_err;
    atp_pkg::t_in       r_in;
    logic               r_oval;
    atp_pkg::t_out      r_out;

    // sine polynomial registers, first pass sine, second pass cosine
    logic               r_cpass;
    logic [16:0]        r_z2;
    logic signed [31:0] r_t;
    logic signed [16:0] r_sin, r_cos;

    atp_pkg::t_mul_req w_req;
    atp_pkg::t_mul_rsp w_rsp;

    logic [15:0]        w_p;
    logic [15:0]        w_tp;
    logic [16:0]        w_z;
    logic signed [31:0] w_t;
    logic signed [16:0] w_sq;
    logic [15:0]        w_sa, w_fa;
    logic signed [67:0] w_prod;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        if (x > 68'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (x < -68'sh80000000) return 32'sh80000000;
        return 32'(x);
    endfunction

    atp_serial_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign w_prod = w_rsp.p;
    assign w_p    = (r_ang >> Shift) << Shift;
    assign w_tp   = r_cpass ? (w_p + 16'd16384) : w_p;
    assign w_z    = w_tp[14] ? (17'd32768 - {2'b0, w_tp[13:0], 1'b0})
                             : {2'b0, w_tp[13:0], 1'b0};
    assign w_sa   = (r_sa > 16'd32768) ? 16'd32768 : r_sa;
    assign w_fa   = (r_fa > 16'd32768) ? 16'd32768 : r_fa;

    always_comb begin
        w_t  = 32'(w_prod >>> 15);
        w_sq = (w_t > 32'sd32767) ? 17'sd32767 : 17'(w_t);
        if (w_tp[15]) w_sq = -w_sq;
    end

    assign o_stall     = (r_state != S_IDLE) || r_oval;
    assign o_cfg_ready = (r_state == S_IDLE) && !r_oval;
    assign o_valid     = r_oval;
    assign o_data      = r_out;

    always_comb begin
        w_req.start = 1'b0;
        w_req.a = '0;
        w_req.b = '0;
        unique case (r_state)
            S_SZ2: begin w_req.a = {17'd0, w_z}; w_req.b = {17'd0, w_z}; end
            S_ST1: begin w_req.a = 34'sd2320; w_req.b = {17'd0, r_z2}; end
            S_ST2: begin w_req.a = 34'(r_t); w_req.b = {17'd0, r_z2}; end
            S_ST3: begin w_req.a = 34'(r_t); w_req.b = {17'd0, w_z}; end
            S_SIN: begin w_req.a = 34'(r_in.alpha_in); w_req.b = 34'(r_sin); end
            S_COS: begin w_req.a = 34'(r_in.beta_in);  w_req.b = 34'(r_cos); end
            S_FFD: begin
                w_req.a = 34'($signed(r_in.angle_in - r_prev));
                w_req.b = {16'd0, r_rate};
            end
            S_FFA: begin w_req.a = 34'(r_tmp); w_req.b = {18'd0, w_fa}; end
            S_FFB: begin w_req.a = 34'(r_ffd); w_req.b = 34'(17'd32768 - {1'b0, w_fa}); end
            S_INT: begin w_req.a = 34'(r_ki); w_req.b = 34'(r_err); end
            S_PRP: begin w_req.a = 34'(r_kp); w_req.b = 34'(r_err); end
            S_LPA: begin w_req.a = 34'(r_omega); w_req.b = {18'd0, w_sa}; end
            S_LPB: begin w_req.a = 34'(r_fspd); w_req.b = 34'(17'd32768 - {1'b0, w_sa}); end
            S_ANG: begin w_req.a = 34'(r_omega); w_req.b = {2'b0, r_per}; end
            default: ;
        endcase
        w_req.start = !r_issued && (r_state != S_IDLE) && (r_state != S_VERR)
            && (r_state != S_OUT) && (r_state != S_WAIT);
    end

    logic signed [67:0] r_acc2;
    logic signed [67:0] n_acc2;
    logic [31:0] w_phase;

    always_comb begin
        w_phase = {r_ang, r_frac} + 32'(w_prod >>> 16);
    end

    always_comb begin
        n_state = r_state;
        n_issued = r_issued;
        n_acc2 = r_acc2;
        if (w_req.start) n_issued = 1'b1;
        unique case (r_state)
            S_IDLE: if (i_valid && !r_oval) begin
                n_issued = 1'b0;
                unique case (i_data.cmd)
                    atp_pkg::CMD_VECTOR: n_state = S_SZ2;
                    atp_pkg::CMD_ANGLE:  n_state = S_FFD;
                    default:             n_state = S_INT;
                endcase
            end
            S_WAIT: n_state = S_INT;
            S_VERR: n_state = S_WAIT;
            S_OUT:  n_state = S_IDLE;
            default: if (w_rsp.done) begin
                n_issued = 1'b0;
                unique case (r_state)
                    S_SZ2: n_state = S_ST1;
                    S_ST1: n_state = S_ST2;
                    S_ST2: n_state = S_ST3;
                    S_ST3: n_state = r_cpass ? S_SIN : S_SZ2;
                    S_SIN: n_state = S_COS;
                    S_COS: n_state = S_VERR;
                    S_FFD: n_state = S_FFA;
                    S_FFA: n_state = S_FFB;
                    S_FFB: n_state = S_INT;
                    S_INT: n_state = S_PRP;
                    S_PRP: n_state = S_LPA;
                    S_LPA: n_state = S_LPB;
                    S_LPB: n_state = S_ANG;
                    S_ANG: n_state = S_OUT;
                    default: n_state = S_IDLE;
                endcase
            end
        endcase
        if (w_rsp.done && (r_state == S_SIN || r_state == S_FFA || r_state == S_LPA)) begin
            n_acc2 = w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_issued <= 1'b0; r_oval <= 1'b0;
            r_kp <= '0; r_ki <= '0; r_sa <= 16'd32768; r_fa <= 16'd32768;
            r_per <= '0; r_rate <= 18'd10000;
            r_integ <= '0; r_fspd <= '0; r_ffd <= '0; r_ang <= '0;
            r_frac <= '0; r_prev <= '0; r_err <= '0; r_cpass <= 1'b0;
        end else begin
            r_state <= n_state; r_issued <= n_issued;
            if (r_oval && !i_stall) r_oval <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    atp_pkg::REG_PROP_GAIN:   r_kp <= i_cfg_data;
                    atp_pkg::REG_INTEG_GAIN:  r_ki <= i_cfg_data;
                    atp_pkg::REG_SPEED_ALPHA: r_sa <= i_cfg_data[15:0];
                    atp_pkg::REG_PERIOD:      r_per <= i_cfg_data;
                    atp_pkg::REG_RATE:        r_rate <= i_cfg_data[17:0];
                    atp_pkg::REG_FFD_ALPHA:   r_fa <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (r_state == S_IDLE && i_valid && !r_oval) r_cpass <= 1'b0;
            if (r_state == S_IDLE && i_valid && !r_oval && i_data.cmd == atp_pkg::CMD_ERROR) begin
                r_err <= i_data.error_in[15:0];
            end
            if (r_state == S_IDLE && i_valid && !r_oval && i_data.cmd == atp_pkg::CMD_ANGLE) begin
                r_err <= i_data.angle_in - r_ang;
            end
            if (w_rsp.done) begin
                unique case (r_state)
                    S_SZ2: r_z2 <= 17'(w_prod >>> 15);
                    S_ST1: r_t <= 32'sd21024 - 32'(w_prod >>> 15);
                    S_ST2: r_t <= 32'sd51472 - 32'(w_prod >>> 15);
                    S_ST3: begin
                        if (r_cpass) r_cos <= w_sq;
                        else r_sin <= w_sq;
                        r_cpass <= 1'b1;
                    end
                    S_COS: r_tmp <= sat32((w_prod - r_acc2) >>> 14);
                    S_FFD: begin r_tmp <= sat32(w_prod); r_prev <= r_in.angle_in; end
                    S_FFB: r_ffd <= sat32((r_acc2 + w_prod) >>> 15);
                    S_INT: r_integ <= sat32(68'(r_integ) + (w_prod >>> 16));
                    S_PRP: r_omega <= sat32((w_prod >>> 16) + 68'(r_integ));
                    S_LPB: r_fspd <= sat32((r_acc2 + w_prod) >>> 15);
                    S_ANG: begin r_ang <= w_phase[31:16]; r_frac <= w_phase[15:0]; end
                    default: ;
                endcase
            end
            if (r_state == S_VERR) begin
                if (r_tmp > 32'sd32767) r_err <= 16'sh7FFF;
                else if (r_tmp < -32'sd32768) r_err <= 16'sh8000;
                else r_err <= r_tmp[15:0];
            end
            if (r_state == S_OUT) r_oval <= 1'b1;
        end
        if (r_state == S_IDLE && i_valid) r_in <= i_data;
        r_acc2 <= n_acc2;
        if (r_state == S_OUT) begin
            r_out.angle_out          <= r_ang;
            r_out.speed_out          <= r_omega;
            r_out.filtered_speed_out <= r_fspd;
            r_out.phase_error_out    <= r_err;
            r_out.ffd_speed_out      <= r_ffd;
        end
    end

    `ATP_ASSERT_IMPL(a_busy_stalls, i_clk, i_rst_n, r_state != S_IDLE, o_stall)
    `ATP_ASSERT_NEXT(a_out_after_seq, i_clk, i_rst_n, r_state == S_OUT, o_valid)
    `ATP_ASSERT_IMPL(a_no_cfg_busy, i_clk, i_rst_n, r_state != S_IDLE, !o_cfg_ready)
endmodule
